/* design/ltfa_pkg.sv */
// Package for the light-trail frame accumulator: sizes, register indexes,
// operation codes and the transaction payload structs.
// No dependencies.
package ltfa_pkg;

  // Frame store geometry.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Fixed field widths.
  localparam int X_W    = 11;
  localparam int Y_W    = 11;
  localparam int CH_W   = 8;
  localparam int FF_W   = 16;
  localparam int FW_W   = 12;
  localparam int CFG_W  = 16;
  localparam int NUM_CH = 3;
  localparam int PIX_W  = NUM_CH * CH_W;

  // Width used for the effective frame width and the mirrored column.
  localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
  localparam int CALC_W  = ((FW_W > MW_BITS) ? FW_W : MW_BITS) + 1;

  // Register reset values.
  localparam logic       FADE_EN_RST  = 1'b0;
  localparam logic       ACC_MODE_RST = 1'b1;
  localparam logic [FF_W-1:0] FADE_FACTOR_RST = 16'd64881;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 12'd1920;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FADE_EN     = 2'd0,
    CFG_ACC_MODE    = 2'd1,
    CFG_FADE_FACTOR = 2'd2,
    CFG_FRAME_WIDTH = 2'd3
  } cfg_idx_e;

  // Operation codes.
  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  // Sequencer states.
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ltfa_state_e;

  typedef struct packed {
    logic            operation;
    logic [X_W-1:0]  pix_x;
    logic [Y_W-1:0]  pix_y;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [X_W-1:0]  out_x;
    logic [Y_W-1:0]  out_y;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } out_item_t;

endpackage

/* design/ltfa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// A read at the address written in the same cycle returns the old data.
// No dependencies.
module ltfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/light_trail_frame_accumulator_core.sv */
// Top level of the light-trail frame accumulator: mirrors, fades and
// max-accumulates camera pixels in a frame store held in ltfa_ram.
// Depends on ltfa_pkg and ltfa_ram.
//
//  Channel | Signals                                  | Direction
//  --------+------------------------------------------+-----------
//  input   | in_valid_i, in_stall_o, in_data_i        | pixel in
//  output  | out_valid_o, out_stall_i, out_data_o     | pixel out
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i         | register write
//
// One transaction per cycle is accepted while in_stall_o is low; the accepting
// edge registers the store read into stage 1, and the modify and write-back
// result is then registered into the output register when stage 1 advances.
// After reset the store is swept to zero, one entry a cycle, over all
// STORE_DEPTH (4194304) entries, with in_stall_o high meanwhile.
// A stalled output holds the pipeline; back-to-back hits on one pixel are
// forwarded from the previous write.
module light_trail_frame_accumulator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ltfa_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ltfa_pkg::out_item_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [ltfa_pkg::CFG_W-1:0] cfg_wdata_i
);
  import ltfa_pkg::*;

  // Configuration registers.
  logic            fade_en_q;
  logic            acc_mode_q;
  logic [FF_W-1:0] fade_factor_q;
  logic [FW_W-1:0] frame_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_en_q     <= FADE_EN_RST;
      acc_mode_q    <= ACC_MODE_RST;
      fade_factor_q <= FADE_FACTOR_RST;
      frame_width_q <= FRAME_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FADE_EN:     fade_en_q     <= cfg_wdata_i[0];
        CFG_ACC_MODE:    acc_mode_q    <= cfg_wdata_i[0];
        CFG_FADE_FACTOR: fade_factor_q <= cfg_wdata_i[FF_W-1:0];
        CFG_FRAME_WIDTH: frame_width_q <= cfg_wdata_i[FW_W-1:0];
        default: ;
      endcase
    end
  end

  // Sweep sequencer that zeroes the store after reset.
  ltfa_state_e       st_q, st_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      st_q      <= st_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    st_d      = st_q;
    clr_cnt_d = clr_cnt_q;
    case (st_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
          st_d      = ST_RUN;
          clr_cnt_d = '0;
        end
      end
      ST_RUN: ;
      default: st_d = ST_CLEAR;
    endcase
  end

  // Handshake control.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic in_accept;
  logic s1_adv;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = (st_q != ST_RUN) || (s1_valid_q && !out_ready);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Stage 0: effective width, frame check, mirrored column and address.
  logic [CALC_W-1:0] fw_ext;
  logic [CALC_W-1:0] eff_w;
  logic [CALC_W-1:0] px_ext;
  logic [CALC_W-1:0] mx;
  logic              in_frame;
  logic [31:0]       addr_full;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    fw_ext = CALC_W'(frame_width_q);
    if (fw_ext > CALC_W'(MAX_WIDTH)) begin
      eff_w = CALC_W'(MAX_WIDTH);
    end else if (fw_ext == '0) begin
      eff_w = CALC_W'(1);
    end else begin
      eff_w = fw_ext;
    end
    px_ext    = CALC_W'(in_data_i.pix_x);
    in_frame  = (px_ext < eff_w) && (32'(in_data_i.pix_y) < 32'(MAX_HEIGHT));
    mx        = eff_w - CALC_W'(1) - px_ext;
    addr_full = 32'(in_data_i.pix_y) * 32'(MAX_WIDTH) + 32'(mx);
    rd_addr   = addr_full[ADDR_W-1:0];
  end

  // Store write port, shared by the sweep and the write-back.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PIX_W-1:0]  ram_wdata;
  logic [PIX_W-1:0]  ram_rdata;
  logic              s1_we;
  logic [PIX_W-1:0]  s1_wdata;

  // Stage 1 registers.
  logic              s1_clear_q;
  logic              s1_in_frame_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [X_W-1:0]    s1_x_q;
  logic [Y_W-1:0]    s1_y_q;
  logic [NUM_CH-1:0][CH_W-1:0] s1_sample_q;
  logic              s1_fwd_q;
  logic [PIX_W-1:0]  fwd_data_q;

  assign s1_we     = s1_adv && s1_in_frame_q;
  assign ram_we    = (st_q == ST_CLEAR) || s1_we;
  assign ram_waddr = (st_q == ST_CLEAR) ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = (st_q == ST_CLEAR) ? '0 : s1_wdata;

  ltfa_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_accept),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Stage 1 valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (out_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 1 payload; a write to the read address in the same cycle is
  // captured for forwarding since the RAM returns the old data.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_clear_q    <= (in_data_i.operation == OP_CLEAR);
      s1_in_frame_q <= in_frame;
      s1_addr_q     <= rd_addr;
      s1_x_q        <= in_frame ? mx[X_W-1:0] : '0;
      s1_y_q        <= in_data_i.pix_y;
      s1_sample_q   <= {in_data_i.in_blue, in_data_i.in_green, in_data_i.in_red};
      s1_fwd_q      <= ram_we && (ram_waddr == rd_addr);
      fwd_data_q    <= ram_wdata;
    end
  end

  // Stage 1 modify: fade, per-channel maximum and write-back value.
  logic [NUM_CH-1:0][CH_W-1:0] stored;
  logic [NUM_CH-1:0][CH_W-1:0] faded;
  logic [NUM_CH-1:0][CH_W-1:0] shown;
  logic [NUM_CH-1:0][CH_W-1:0] kept;
  logic [NUM_CH-1:0][CH_W-1:0] disp;
  logic [NUM_CH-1:0][CH_W+FF_W-1:0] prod;

  always_comb begin
    stored = s1_fwd_q ? fwd_data_q : ram_rdata;
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c]  = (CH_W+FF_W)'(stored[c]) * (CH_W+FF_W)'(fade_factor_q);
      faded[c] = fade_en_q ? prod[c][CH_W+FF_W-1:FF_W] : stored[c];
      shown[c] = (faded[c] > s1_sample_q[c]) ? faded[c] : s1_sample_q[c];
      kept[c]  = acc_mode_q ? shown[c] : faded[c];
    end
    s1_wdata = s1_clear_q ? '0 : kept;
    disp     = (s1_clear_q || !s1_in_frame_q) ? '0 : shown;
  end

  // Output register.
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q.out_x     <= s1_x_q;
      out_data_q.out_y     <= s1_y_q;
      out_data_q.out_red   <= disp[0];
      out_data_q.out_green <= disp[1];
      out_data_q.out_blue  <= disp[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // No transaction is taken before the store sweep has finished.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> st_q == ST_RUN)
    else $error("input accepted during store sweep");

  // The sweep ends only after the last entry has been written.
  a_sweep_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) && ($past(st_q) == ST_CLEAR)
      |-> $past(clr_cnt_q) == ADDR_W'(STORE_DEPTH - 1))
    else $error("store sweep ended early");

  // A held stage 1 keeps its address so the write-back lands correctly.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_ready |=> s1_valid_q && $stable(s1_addr_q))
    else $error("stage 1 lost while stalled");

  // A new result only appears when stage 1 held an item.
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a stage 1 item");

  // Store writes from the pipeline occur only in the run state.
  a_we_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_we |-> st_q == ST_RUN)
    else $error("pipeline write during sweep");

endmodule
